### rtl/lgts_pkg.sv
// Package for the LDA Gibbs topic sampler: sizes, widths and shared types.
// No dependencies.
package lgts_pkg;
    localparam int MAX_TOPICS = 64;
    localparam int MAX_VOCAB  = 4096;
    localparam int MAX_DOCS   = 256;
    localparam int MAX_TOKENS = 16384;
    localparam int TW  = $clog2(MAX_TOPICS);
    localparam int VW  = $clog2(MAX_VOCAB);
    localparam int DW  = $clog2(MAX_DOCS);
    localparam int SW  = $clog2(MAX_TOKENS);
    localparam int CW  = 15;
    localparam logic [CW-1:0] CNT_MAX = 15'h7FFF;
    // a,b up to 2^23+2^16, product < 2^47; d up to 2^29
    localparam int AW  = 24;
    localparam int PW  = 48;
    localparam int DDW = 30;
    localparam int WW  = 48;
    localparam int SUMW = 56;

    localparam logic [1:0] REG_TOPICS = 2'd0;
    localparam logic [1:0] REG_VOCAB  = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;
    localparam logic [1:0] REG_BETA   = 2'd3;

    typedef struct packed {
        logic          start;
        logic [PW-1:0] num;
        logic [DDW-1:0] den;
    } lgts_div_req_t;
endpackage

### rtl/lgts_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module lgts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/lgts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lgts_pkg.
module lgts_div import lgts_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  lgts_div_req_t req,
    output logic          done,
    output logic [WW-1:0] quot
);
    localparam int CNTW = $clog2(PW + 1);
    logic [PW-1:0]   q_reg;
    logic [DDW:0]    r_reg;
    logic [DDW-1:0]  d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;
    logic [DDW:0]    trial;

    assign trial = {r_reg[DDW-1:0], q_reg[PW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && (cnt_reg == CNTW'(1));
            if (req.start) begin
                busy_reg <= 1'b1;
                q_reg    <= req.num;
                d_reg    <= req.den;
                r_reg    <= '0;
                cnt_reg  <= CNTW'(PW);
            end else if (busy_reg) begin
                if (trial >= {1'b0, d_reg}) begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[PW-2:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[PW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = WW'(q_reg);
endmodule

### rtl/lda_gibbs_topic_sampler.sv
// Collapsed Gibbs LDA topic sampler. After reset the count memories are cleared, one
// entry per cycle, before the first item is accepted. Items are taken one at a time:
// s_ready is high only while the block is idle. An init item runs random_value mod
// num_topics through the shared bit-serial divider (48 steps), then counts its topic and
// presents it. A resample item removes the old topic, computes a weight per topic (48
// divider steps each), forms the threshold, scans topics up to the chosen one, then
// counts and returns it. A result still waiting on m_ready holds the final stage.
// Depends on lgts_pkg, lgts_ram and lgts_div.
module lda_gibbs_topic_sampler import lgts_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_action,
    input  logic [7:0]    s_doc_index,
    input  logic [13:0]   s_token_slot,
    input  logic [11:0]   s_word_id,
    input  logic [15:0]   s_random_value,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [5:0]    m_topic
);
    localparam int WAW = VW + TW;
    localparam int DAW = DW + TW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RDOLD, S_OLDW, S_DEC, S_DECW, S_RD, S_RDW, S_DIV,
        S_ACC, S_THR, S_SCAN, S_SCANW, S_INC, S_INCW, S_OUT
    } state_t;
    state_t state_reg;

    logic [6:0]  nt_cfg_reg;
    logic [12:0] nv_cfg_reg;
    logic [15:0] alpha_reg, beta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nt_cfg_reg <= 7'd8;
            nv_cfg_reg <= 13'd4096;
            alpha_reg  <= 16'd256;
            beta_reg   <= 16'd26;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TOPICS: nt_cfg_reg <= cfg_data[6:0];
                REG_VOCAB:  nv_cfg_reg <= cfg_data[12:0];
                REG_ALPHA:  alpha_reg  <= cfg_data;
                REG_BETA:   beta_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [TW:0] nt;
    logic [VW:0] nv;
    always_comb begin
        nt = (nt_cfg_reg == 7'd0) ? (TW+1)'(1)
           : (nt_cfg_reg > 7'(MAX_TOPICS)) ? (TW+1)'(MAX_TOPICS) : (TW+1)'(nt_cfg_reg);
        nv = (nv_cfg_reg == 13'd0) ? (VW+1)'(1)
           : (nv_cfg_reg > 13'(MAX_VOCAB)) ? (VW+1)'(MAX_VOCAB) : (VW+1)'(nv_cfg_reg);
    end

    // item registers
    logic          act_reg;
    logic [DW-1:0] doc_reg;
    logic [SW-1:0] slot_reg;
    logic [VW-1:0] word_reg;
    logic [15:0]   u_reg;
    logic [TW-1:0] k_reg, t_reg;
    logic [TW:0]   cnt_reg;
    logic [WAW-1:0] clr_reg;
    logic [TW-1:0] topic_reg;
    logic          mv_reg;

    // memories
    logic          tok_we;  logic [TW-1:0] tok_rd;
    logic          cnt_we;
    logic [WAW-1:0] w_waddr, w_raddr; logic [CW-1:0] w_wdata, w_rd;
    logic [DAW-1:0] d_waddr, d_raddr; logic [CW-1:0] d_wdata, d_rd;
    logic [TW-1:0]  z_waddr, z_raddr; logic [CW-1:0] z_wdata, z_rd;
    logic           sum_we; logic [SUMW-1:0] sum_rd, total_reg;

    lgts_ram #(.WIDTH(TW), .DEPTH(MAX_TOKENS)) u_tok (
        .aclk, .we(tok_we), .waddr(slot_reg), .wdata(t_reg),
        .raddr(slot_reg), .rdata(tok_rd));
    lgts_ram #(.WIDTH(CW), .DEPTH(MAX_VOCAB*MAX_TOPICS)) u_wt (
        .aclk, .we(cnt_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rd));
    lgts_ram #(.WIDTH(CW), .DEPTH(MAX_DOCS*MAX_TOPICS)) u_dt (
        .aclk, .we(cnt_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rd));
    lgts_ram #(.WIDTH(CW), .DEPTH(MAX_TOPICS)) u_zt (
        .aclk, .we(cnt_we), .waddr(z_waddr), .wdata(z_wdata),
        .raddr(z_raddr), .rdata(z_rd));
    lgts_ram #(.WIDTH(SUMW), .DEPTH(MAX_TOPICS)) u_cum (
        .aclk, .we(sum_we), .waddr(k_reg), .wdata(total_reg),
        .raddr(k_reg), .rdata(sum_rd));

    logic clearing, up;
    assign clearing = (state_reg == S_CLEAR);
    assign up = (state_reg == S_INCW);
    assign w_raddr = {word_reg, k_reg};
    assign d_raddr = {doc_reg, k_reg};
    assign z_raddr = k_reg;
    assign w_waddr = clearing ? clr_reg : {word_reg, k_reg};
    assign d_waddr = clearing ? DAW'(clr_reg) : {doc_reg, k_reg};
    assign z_waddr = clearing ? TW'(clr_reg) : k_reg;

    function automatic logic [CW-1:0] adj(input logic [CW-1:0] c, input logic inc);
        if (inc) adj = (c == CNT_MAX) ? c : c + 1'b1;
        else     adj = (c == '0) ? c : c - 1'b1;
    endfunction

    assign w_wdata = clearing ? '0 : adj(w_rd, up);
    assign d_wdata = clearing ? '0 : adj(d_rd, up);
    assign z_wdata = clearing ? '0 : adj(z_rd, up);
    assign cnt_we  = clearing || state_reg == S_DECW || state_reg == S_INCW;
    assign tok_we  = (state_reg == S_INCW);
    assign sum_we  = (state_reg == S_ACC);

    // weight arithmetic, registered between the multiply and the divide
    logic [AW-1:0] a_val, b_val;
    logic [PW-1:0] prod_reg;
    logic [DDW-1:0] den_reg;
    logic [DDW-1:0] bv;
    assign a_val = {1'b0, w_rd, 8'd0} + AW'(beta_reg);
    assign b_val = {1'b0, d_rd, 8'd0} + AW'(alpha_reg);
    assign bv    = DDW'(beta_reg) * DDW'(nv);

    lgts_div_req_t dreq;
    logic          ddone;
    logic [WW-1:0] dq;
    logic          dstart_reg;
    assign dreq.start = dstart_reg;
    assign dreq.num   = prod_reg;
    assign dreq.den   = den_reg;
    lgts_div u_div (.aclk, .aresetn, .req(dreq), .done(ddone), .quot(dq));

    // init items: random_value mod topics from the divider's quotient
    logic [15:0] mod_rem;
    assign mod_rem = u_reg - dq[15:0] * 16'(nt);

    // threshold = floor(u*total/65536), two partial products
    logic [SUMW-1:0] thr_reg, ph_reg;
    logic [31:0]     pl_reg;
    logic            thr_ph_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_topic = topic_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            mv_reg     <= 1'b0;
            dstart_reg <= 1'b0;
        end else begin
            dstart_reg <= (state_reg == S_RDW) || (state_reg == S_IDLE && s_valid && !s_action);
            if (state_reg == S_OUT && (!mv_reg || m_ready)) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_valid) begin
                    act_reg  <= s_action;
                    doc_reg  <= s_doc_index;
                    slot_reg <= s_token_slot;
                    word_reg <= s_word_id;
                    u_reg    <= s_random_value;
                    if (s_action) begin
                        state_reg <= S_RDOLD;
                    end else begin
                        prod_reg  <= PW'(s_random_value);
                        den_reg   <= DDW'(nt);
                        state_reg <= S_DIV;
                    end
                end
                S_RDOLD: state_reg <= S_OLDW;
                S_OLDW: begin
                    k_reg <= tok_rd;
                    state_reg <= S_DEC;
                end
                S_DEC: state_reg <= S_DECW;
                S_DECW: begin
                    k_reg <= '0; cnt_reg <= '0; total_reg <= '0;
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= S_RDW;
                S_RDW: begin
                    prod_reg <= PW'(a_val) * PW'(b_val);
                    den_reg  <= {z_rd, 8'd0} + bv;
                    state_reg <= S_DIV;
                end
                S_DIV: if (ddone) begin
                    if (act_reg) begin
                        total_reg <= total_reg + ((den_reg == '0) ? '0 : SUMW'(dq));
                        state_reg <= S_ACC;
                    end else begin
                        t_reg <= mod_rem[TW-1:0];
                        k_reg <= mod_rem[TW-1:0];
                        state_reg <= S_INC;
                    end
                end
                S_ACC: begin
                    if (cnt_reg + 1'b1 == nt) begin
                        thr_ph_reg <= 1'b0;
                        state_reg <= S_THR;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_THR: begin
                    if (!thr_ph_reg) begin
                        ph_reg <= SUMW'(u_reg * total_reg[SUMW-1:16]);
                        pl_reg <= u_reg * total_reg[15:0];
                        thr_ph_reg <= 1'b1;
                    end else begin
                        thr_reg <= ph_reg + SUMW'(pl_reg[31:16]);
                        k_reg <= '0; cnt_reg <= '0; t_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: state_reg <= S_SCANW;
                S_SCANW: begin
                    if (sum_rd >= thr_reg) begin
                        t_reg <= k_reg;
                        state_reg <= S_INC;
                    end else if (cnt_reg + 1'b1 == nt) begin
                        t_reg <= '0;
                        k_reg <= '0;
                        state_reg <= S_INC;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                // k_reg already holds the new topic, so this cycle reads its counts
                S_INC: state_reg <= S_INCW;
                S_INCW: state_reg <= S_OUT;
                S_OUT: if (!mv_reg || m_ready) begin
                    topic_reg <= 6'(t_reg);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
`ifndef ASSERT_OFF
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready) else $error("accept during clear");
    a_div_once: assert property (@(posedge aclk) disable iff (!aresetn)
        dstart_reg |-> state_reg == S_DIV) else $error("stray divide start");
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCANW |-> cnt_reg < nt) else $error("scan past topics");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_topic))
        else $error("waiting item dropped or changed");
`endif
endmodule
